// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");
// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");
`else
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/knn_pkg.sv =====
// Types, widths and codes of the k-nearest-neighbour sorter.
`default_nettype none
package knn_pkg;

  localparam int INDEX_BITS         = 20;
  localparam int COORD_BITS         = 16;
  localparam int COORD_FIELDS       = 4;
  localparam int MAX_DIMS           = 4;
  localparam int DIST_BITS          = 2 * COORD_BITS + $clog2(COORD_FIELDS);
  localparam int MAX_NEIGHBOURS_DEF = 16;
  localparam int K_CFG_W            = 5;
  localparam int DIMS_CFG_W         = 3;
  localparam int CFG_INDEX_W        = 3;
  localparam int CFG_DATA_W         = 16;
  localparam int DIMS_LIMIT         = (MAX_DIMS < COORD_FIELDS) ? MAX_DIMS : COORD_FIELDS;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NEIGHBOURS = 3'd0,
    REG_DIMS       = 3'd1,
    REG_QUERY_0    = 3'd2,
    REG_QUERY_1    = 3'd3,
    REG_QUERY_2    = 3'd4,
    REG_QUERY_3    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]        point_index;
    logic signed [COORD_BITS-1:0] coord_0;
    logic signed [COORD_BITS-1:0] coord_1;
    logic signed [COORD_BITS-1:0] coord_2;
    logic signed [COORD_BITS-1:0] coord_3;
    logic                         first_point;
    logic                         last_point;
  } point_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] neighbour_index;
    logic [DIST_BITS-1:0]  neighbour_distance;
    logic                  neighbour_valid;
    logic                  last_result;
  } result_t;

  // Point tag carried alongside the distance pipeline.
  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic                  first_point;
    logic                  last_point;
  } tag_t;

  typedef struct packed {
    tag_t                 tag;
    logic [DIST_BITS-1:0] distance;
  } dist_item_t;

  // One slot of the sorted list.
  typedef struct packed {
    logic                  valid;
    logic [DIST_BITS-1:0]  distance;
    logic [INDEX_BITS-1:0] index;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/knn_dist.sv =====
// Three-stage squared Euclidean distance pipeline.
`default_nettype none
module knn_dist (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  knn_pkg::point_t                      in_point,
  input  logic [knn_pkg::COORD_BITS-1:0]       query [knn_pkg::COORD_FIELDS],
  input  logic [knn_pkg::DIMS_CFG_W-1:0]       dims,
  output logic                                 out_valid,
  output knn_pkg::dist_item_t                  out_item
);
  import knn_pkg::*;

  logic [COORD_BITS-1:0]       coord [COORD_FIELDS];
  logic signed [COORD_BITS:0]  diff [COORD_FIELDS];
  logic [COORD_BITS-1:0]       mag_next [COORD_FIELDS];
  logic [COORD_BITS-1:0]       mag [COORD_FIELDS];
  logic [2*COORD_BITS-1:0]     sq [COORD_FIELDS];
  logic [DIST_BITS-1:0]        sum_next;
  logic                        s1_valid, s2_valid;
  tag_t                        s1_tag, s2_tag;

  assign coord[0] = in_point.coord_0;
  assign coord[1] = in_point.coord_1;
  assign coord[2] = in_point.coord_2;
  assign coord[3] = in_point.coord_3;

  // |query - coord| per dimension, zero for unused dimensions
  always_comb begin
    for (int j = 0; j < COORD_FIELDS; j++) begin
      diff[j] = $signed({query[j][COORD_BITS-1], query[j]})
              - $signed({coord[j][COORD_BITS-1], coord[j]});
      mag_next[j] = diff[j][COORD_BITS] ? COORD_BITS'(-diff[j]) : diff[j][COORD_BITS-1:0];
      if (!(DIMS_CFG_W'(j) < dims)) begin
        mag_next[j] = '0;
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int j = 0; j < COORD_FIELDS; j++) begin
      sum_next = sum_next + DIST_BITS'(sq[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag <= '{index: in_point.point_index, first_point: in_point.first_point,
                last_point: in_point.last_point};
    mag    <= mag_next;
    s2_tag <= s1_tag;
    for (int j = 0; j < COORD_FIELDS; j++) begin
      sq[j] <= (2*COORD_BITS)'(mag[j]) * (2*COORD_BITS)'(mag[j]);
    end
    out_item.tag      <= s2_tag;
    out_item.distance <= sum_next;
  end

endmodule
`default_nettype wire

// ===== rtl/knn_cell.sv =====
// One slot of the shift-insert sorting chain.
`default_nettype none
module knn_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            insert,
  input  logic            flush,
  input  logic            keep_slot,
  input  knn_pkg::entry_t cand,
  input  knn_pkg::entry_t left,
  input  logic            left_beats,
  output knn_pkg::entry_t entry,
  output logic            beats
);
  import knn_pkg::*;

  logic                  vld;
  logic [DIST_BITS-1:0]  distance;
  logic [INDEX_BITS-1:0] index;
  logic                  own_vld;

  // Slot as seen by this item: emptied by a first point or when beyond k.
  assign own_vld = vld && !flush && keep_slot;
  assign entry   = '{valid: own_vld, distance: distance, index: index};
  // An empty slot loses to anything; ties keep the older entry.
  assign beats   = !own_vld || (cand.distance < distance);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (insert) begin
      if (!keep_slot) begin
        vld <= 1'b0;
      end else if (beats) begin
        vld <= left_beats ? left.valid : cand.valid;
      end else begin
        vld <= own_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (insert && keep_slot && beats) begin
      distance <= left_beats ? left.distance : cand.distance;
      index    <= left_beats ? left.index : cand.index;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/knn_top_k_distance_sorter.sv =====
// Top level of the k-nearest-neighbour distance sorter.
// Each accepted point word gets its squared distance to the configured query
// point in a three-stage pipeline (difference, square, sum) and then enters a
// chain of MAX_NEIGHBOURS slot cells: every cell compares the broadcast
// distance with its own and either keeps its entry, takes its left
// neighbour's entry or takes the new point, so the list stays sorted by
// ascending distance with empty slots at the end and older entries ahead on
// ties. Points stream at one word per cycle while not stalled. Once a word
// with last_point is accepted, point_stall stays high through pipeline drain
// and the emission of k words (longer if result_stall holds words back),
// then drops as the final result word is loaded; the final word may still
// wait on result_stall while new points flow in. Results are k words, slot
// 0 first, with last_result on slot k-1. Configuration writes go straight
// into the registers and must only be made while no point is in flight.
`default_nettype none
`include "assert_macros.svh"
module knn_top_k_distance_sorter #(
  parameter int MAX_NEIGHBOURS = knn_pkg::MAX_NEIGHBOURS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             point_valid,
  output logic                             point_stall,
  input  knn_pkg::point_t                  point_word,
  output logic                             result_valid,
  input  logic                             result_stall,
  output knn_pkg::result_t                 result_word,
  input  logic                             cfg_write,
  input  logic [knn_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [knn_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import knn_pkg::*;

  localparam int K_W   = $clog2(MAX_NEIGHBOURS + 1);
  localparam int IDX_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

  // config registers
  logic [K_CFG_W-1:0]    nbr_cfg;
  logic [DIMS_CFG_W-1:0] dims_cfg;
  logic [COORD_BITS-1:0] query [COORD_FIELDS];

  logic [K_W-1:0]        k_eff;
  logic [K_W-1:0]        k_last;
  logic [DIMS_CFG_W-1:0] dims_eff;

  logic                  point_accept;
  logic                  dist_valid;
  dist_item_t            dist_item;
  entry_t                cand;
  entry_t                entries [MAX_NEIGHBOURS];
  logic [MAX_NEIGHBOURS-1:0] beats;
  logic [MAX_NEIGHBOURS-1:0] vld_vec;

  state_t                state, state_next;
  logic                  emit_on;
  logic                  load;
  logic                  cnt_is_last;
  logic [IDX_W-1:0]      cnt;
  entry_t                sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      nbr_cfg  <= K_CFG_W'(1);
      dims_cfg <= DIMS_CFG_W'(3);
      for (int j = 0; j < COORD_FIELDS; j++) begin
        query[j] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_NEIGHBOURS: nbr_cfg  <= cfg_data[K_CFG_W-1:0];
        REG_DIMS:       dims_cfg <= cfg_data[DIMS_CFG_W-1:0];
        REG_QUERY_0:    query[0] <= cfg_data[COORD_BITS-1:0];
        REG_QUERY_1:    query[1] <= cfg_data[COORD_BITS-1:0];
        REG_QUERY_2:    query[2] <= cfg_data[COORD_BITS-1:0];
        REG_QUERY_3:    query[3] <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // k and dims clamped into their usable ranges
  always_comb begin
    if (nbr_cfg == '0) begin
      k_eff = K_W'(1);
    end else if (32'(nbr_cfg) > MAX_NEIGHBOURS) begin
      k_eff = K_W'(MAX_NEIGHBOURS);
    end else begin
      k_eff = K_W'(nbr_cfg);
    end
  end
  assign k_last = k_eff - K_W'(1);

  always_comb begin
    if (dims_cfg == '0) begin
      dims_eff = DIMS_CFG_W'(1);
    end else if (32'(dims_cfg) > DIMS_LIMIT) begin
      dims_eff = DIMS_CFG_W'(DIMS_LIMIT);
    end else begin
      dims_eff = dims_cfg;
    end
  end

  assign point_accept = point_valid && !point_stall;

  knn_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (point_accept),
    .in_point  (point_word),
    .query     (query),
    .dims      (dims_eff),
    .out_valid (dist_valid),
    .out_item  (dist_item)
  );

  assign cand = '{valid: 1'b1, distance: dist_item.distance, index: dist_item.tag.index};

  // insertion chain
  for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
    entry_t left;
    logic   left_beats;
    if (i == 0) begin : g_head
      assign left       = cand;
      assign left_beats = 1'b0;
    end else begin : g_body
      assign left       = entries[i-1];
      assign left_beats = beats[i-1];
    end

    knn_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .insert     (dist_valid),
      .flush      (dist_valid && dist_item.tag.first_point),
      .keep_slot  (K_W'(i) < k_eff),
      .cand       (cand),
      .left       (left),
      .left_beats (left_beats),
      .entry      (entries[i]),
      .beats      (beats[i])
    );

    assign vld_vec[i] = entries[i].valid;
  end

  // sequencer: run, drain pipeline after last point, emit k words
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (point_accept && point_word.last_point) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (dist_valid && dist_item.tag.last_point) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (load && cnt_is_last) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    case (state)
      ST_RUN: begin
        point_stall = 1'b0;
        emit_on     = 1'b0;
      end
      ST_DRAIN: begin
        point_stall = 1'b1;
        emit_on     = 1'b0;
      end
      ST_EMIT: begin
        point_stall = 1'b1;
        emit_on     = 1'b1;
      end
      default: begin
        point_stall = 1'b1;
        emit_on     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // output register, loaded during emission whenever it is empty or being taken
  assign load        = emit_on && (!result_valid || !result_stall);
  assign cnt_is_last = (K_W'(cnt) == k_last);
  assign sel         = entries[cnt];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        cnt <= cnt_is_last ? '0 : cnt + IDX_W'(1);
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_word.neighbour_index    <= sel.valid ? sel.index : '0;
      result_word.neighbour_distance <= sel.valid ? sel.distance : '0;
      result_word.neighbour_valid    <= sel.valid;
      result_word.last_result        <= cnt_is_last;
    end
  end

  // emission only reads a settled list
  `ASSERT_IMPLY(a_emit_drained, clk, rst, state == ST_EMIT, !dist_valid)
  // filled slots always form a prefix of the chain
  `ASSERT_IMPLY(a_list_packed, clk, rst, 1'b1, ((vld_vec + 1'b1) & vld_vec) == '0)
  // the last point closes the input until the list is out
  `ASSERT_NEXT(a_last_stalls, clk, rst, point_accept && point_word.last_point, point_stall)

endmodule
`default_nettype wire

// ===== tb/sv/knn_neighbour_checker.sv =====
// Checker for the k-nearest-neighbour sorter: mirrors config, predicts the neighbour lists, compares.
`timescale 1ns / 1ps
module knn_neighbour_checker
  import knn_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   point_valid,
  input  logic                   point_stall,
  input  point_t                 point_word,
  input  logic                   result_valid,
  input  logic                   result_stall,
  input  result_t                result_word,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     failures,
  output int                     outstanding
);

  localparam int SLOTS = MAX_NEIGHBOURS_DEF;
  localparam int REPORT_LIMIT = 10;

  logic [K_CFG_W-1:0]    k_setting;
  logic [DIMS_CFG_W-1:0] dims_setting;
  logic [COORD_BITS-1:0] query [COORD_FIELDS];

  logic [DIST_BITS-1:0]  slot_dist  [SLOTS];
  logic [INDEX_BITS-1:0] slot_index [SLOTS];
  logic                  slot_full  [SLOTS];

  result_t expected_neighbours [$];
  int      mismatches = 0;
  int      pending_words = 0;

  assign failures    = mismatches;
  assign outstanding = pending_words;

  function automatic logic [DIST_BITS-1:0] squared_distance(input point_t p, input int dims);
    logic [COORD_BITS-1:0] c [COORD_FIELDS];
    logic [COORD_BITS:0]   diff;
    logic [COORD_BITS:0]   mag;
    logic [DIST_BITS-1:0]  sum;
    c[0] = p.coord_0;
    c[1] = p.coord_1;
    c[2] = p.coord_2;
    c[3] = p.coord_3;
    sum = '0;
    for (int d = 0; d < dims; d++) begin
      // 17-bit difference, then magnitude
      diff = {query[d][COORD_BITS-1], query[d]} - {c[d][COORD_BITS-1], c[d]};
      mag  = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
      sum  = sum + DIST_BITS'(mag) * DIST_BITS'(mag);
    end
    return sum;
  endfunction

  task automatic rank_candidate(input point_t p);
    int                   k;
    int                   dims;
    int                   pos;
    logic [DIST_BITS-1:0] cand_dist;
    result_t              r;
    k = int'(k_setting);
    if (k == 0) k = 1;
    if (k > SLOTS) k = SLOTS;
    dims = int'(dims_setting);
    if (dims == 0) dims = 1;
    if (dims > DIMS_LIMIT) dims = DIMS_LIMIT;
    if (p.first_point) begin
      for (int i = 0; i < SLOTS; i++) slot_full[i] = 1'b0;
    end
    for (int i = k; i < SLOTS; i++) slot_full[i] = 1'b0;
    cand_dist = squared_distance(p, dims);
    pos = k - 1;
    // enters only if a slot is free or strictly nearer than the tail
    if (!slot_full[pos] || cand_dist < slot_dist[pos]) begin
      while (pos > 0 && (!slot_full[pos-1] || slot_dist[pos-1] > cand_dist)) begin
        if (slot_full[pos-1]) begin
          slot_dist[pos]  = slot_dist[pos-1];
          slot_index[pos] = slot_index[pos-1];
          slot_full[pos]  = 1'b1;
        end
        pos--;
      end
      slot_dist[pos]  = cand_dist;
      slot_index[pos] = p.point_index;
      slot_full[pos]  = 1'b1;
    end
    if (p.last_point) begin
      for (int i = 0; i < k; i++) begin
        r.neighbour_index    = slot_full[i] ? slot_index[i] : '0;
        r.neighbour_distance = slot_full[i] ? slot_dist[i] : '0;
        r.neighbour_valid    = slot_full[i];
        r.last_result        = (i == k - 1);
        expected_neighbours.push_back(r);
      end
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_neighbours.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: result word with nothing expected: idx %0d dist %0d valid %0b last %0b",
                 $realtime, got.neighbour_index, got.neighbour_distance,
                 got.neighbour_valid, got.last_result);
      mismatches++;
    end else begin
      want = expected_neighbours.pop_front();
      if (got.neighbour_index !== want.neighbour_index ||
          got.neighbour_distance !== want.neighbour_distance ||
          got.neighbour_valid !== want.neighbour_valid ||
          got.last_result !== want.last_result) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: mismatch: expected idx %0d dist %0d valid %0b last %0b, %s%0d %0d %0b %0b",
                   $realtime, want.neighbour_index, want.neighbour_distance,
                   want.neighbour_valid, want.last_result, "got idx/dist/valid/last ",
                   got.neighbour_index, got.neighbour_distance,
                   got.neighbour_valid, got.last_result);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      k_setting    = K_CFG_W'(1);
      dims_setting = DIMS_CFG_W'(3);
      for (int d = 0; d < COORD_FIELDS; d++) query[d] = '0;
      for (int i = 0; i < SLOTS; i++) slot_full[i] = 1'b0;
      expected_neighbours.delete();
      pending_words <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NEIGHBOURS: k_setting    = cfg_data[K_CFG_W-1:0];
          REG_DIMS:       dims_setting = cfg_data[DIMS_CFG_W-1:0];
          REG_QUERY_0:    query[0]     = cfg_data[COORD_BITS-1:0];
          REG_QUERY_1:    query[1]     = cfg_data[COORD_BITS-1:0];
          REG_QUERY_2:    query[2]     = cfg_data[COORD_BITS-1:0];
          REG_QUERY_3:    query[3]     = cfg_data[COORD_BITS-1:0];
          default: ;
        endcase
      end
      if (point_valid && !point_stall) rank_candidate(point_word);
      if (result_valid && !result_stall) check_result(result_word);
      pending_words <= expected_neighbours.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the k-nearest-neighbour sorter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import knn_pkg::*;

  // pipeline drain plus insertion, with margin, before config writes
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_POINTS = 230;
  localparam int PHASE_POINTS  = 40;
  // long receiver hold-off, starts once this many point words went in
  localparam int HOLD_AT       = 70;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_NS      = 2_000_000;

  localparam logic [CFG_INDEX_W-1:0] UNMAPPED_REG = CFG_INDEX_W'(REG_QUERY_3 + 1);
  localparam logic [COORD_BITS-1:0]  COORD_MIN    = 16'h8000;
  localparam logic [COORD_BITS-1:0]  COORD_MAX    = 16'h7FFF;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   point_valid = 1'b0;
  logic                   point_stall;
  point_t                 point_word = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result_word;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     failures;
  int                     outstanding;

  // stimulus-side view of the settings, for shaping sequences
  int                     k_now = 1;
  logic [COORD_BITS-1:0]  query_now [COORD_FIELDS] = '{default: '0};

  logic calm = 1'b0;       // no idling on either side
  int   sent_count = 0;    // accepted point words, read by the receiver
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  knn_top_k_distance_sorter i_dut (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_word   (point_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  knn_neighbour_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_word   (point_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .failures     (failures),
    .outstanding  (outstanding)
  );

  // Receiver: random stall, once a long hold-off so the list output backs
  // up and the block stalls its point input while the sender keeps offering.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      result_stall <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(0, 99) < 26);
    end
  end

  // Runaway guard.
  initial begin
    #(LIMIT_NS);
    $display("testbench failed");
    $finish;
  end

  // Offer one point word after a random gap; hold it until taken.
  task automatic offer_point(input point_t p);
    while (!calm && $urandom_range(0, 99) < 26) begin
      point_valid <= 1'b0;
      @(posedge clk);
    end
    point_valid <= 1'b1;
    point_word  <= p;
    do @(posedge clk); while (point_stall);
    sent_count <= sent_count + 1;
  endtask

  // Stop offering until every expected result word is in; with settle,
  // also let the pipeline empty so config writes are safe.
  task automatic wait_for_results(input bit settle);
    point_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // k and dims words may carry junk above their field widths on purpose.
  task automatic apply_config(input logic [CFG_DATA_W-1:0] k_word,
                              input logic [CFG_DATA_W-1:0] dims_word,
                              input logic [CFG_DATA_W-1:0] q0, q1, q2, q3);
    write_reg(UNMAPPED_REG + CFG_INDEX_W'($urandom_range(0, 1)), CFG_DATA_W'($urandom));
    write_reg(REG_NEIGHBOURS, k_word);
    write_reg(REG_DIMS, dims_word);
    write_reg(REG_QUERY_0, q0);
    write_reg(REG_QUERY_1, q1);
    write_reg(REG_QUERY_2, q2);
    write_reg(REG_QUERY_3, q3);
    cfg_write <= 1'b0;
    k_now = int'(k_word[K_CFG_W-1:0]);
    if (k_now == 0) k_now = 1;
    if (k_now > MAX_NEIGHBOURS_DEF) k_now = MAX_NEIGHBOURS_DEF;
    query_now[0] = q0;
    query_now[1] = q1;
    query_now[2] = q2;
    query_now[3] = q3;
  endtask

  function automatic point_t point_of(input int idx, input int c0, c1, c2, c3,
                                      input bit first, input bit last);
    point_t p;
    p.point_index = INDEX_BITS'(idx);
    p.coord_0     = COORD_BITS'(c0);
    p.coord_1     = COORD_BITS'(c1);
    p.coord_2     = COORD_BITS'(c2);
    p.coord_3     = COORD_BITS'(c3);
    p.first_point = first;
    p.last_point  = last;
    return p;
  endfunction

  function automatic logic [COORD_BITS-1:0] extreme_coord();
    case ($urandom_range(0, 3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly near the query (tight offsets give many equal distances),
  // some medium spread, some full range and some extremes.
  function automatic point_t make_point();
    point_t                p;
    logic [COORD_BITS-1:0] c [COORD_FIELDS];
    int                    sel;
    for (int d = 0; d < COORD_FIELDS; d++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5)
        c[d] = query_now[d] + COORD_BITS'($urandom_range(0, 6)) - COORD_BITS'(3);
      else if (sel < 8)
        c[d] = query_now[d] + COORD_BITS'($urandom_range(0, 2000)) - COORD_BITS'(1000);
      else if (sel == 8)
        c[d] = COORD_BITS'($urandom);
      else
        c[d] = extreme_coord();
    end
    p.point_index = INDEX_BITS'($urandom);
    p.coord_0     = c[0];
    p.coord_1     = c[1];
    p.coord_2     = c[2];
    p.coord_3     = c[3];
    p.first_point = 1'b0;
    p.last_point  = 1'b0;
    return p;
  endfunction

  // Well-formed search: first on the opening word, last on the closing one.
  // Noise sequences scatter both flags at random instead.
  task automatic run_sequence(input int len, input bit noise);
    point_t p;
    for (int i = 0; i < len; i++) begin
      p = make_point();
      p.first_point = noise ? 1'($urandom) : (i == 0);
      p.last_point  = noise ? ($urandom_range(0, 3) == 0) : (i == len - 1);
      offer_point(p);
    end
  endtask

  function automatic logic [COORD_BITS-1:0] random_query();
    return ($urandom_range(0, 3) == 0) ? extreme_coord() : COORD_BITS'($urandom);
  endfunction

  initial begin
    int random_left;
    int phase_left;
    int phase;
    int len;
    int k_pick;
    int dims_pick;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // reset settings: k of one, three dims, query at the origin
    offer_point(point_of(0, 0, 0, 0, 0, 1'b1, 1'b1));
    offer_point(point_of(20'hFFFFF, 5, -7, 9, -32768, 1'b1, 1'b1));

    // k of four, full dims, query at MIN, MAX, zero and minus one
    wait_for_results(1'b1);
    apply_config(16'd4, 16'd4, COORD_MIN, COORD_MAX, 16'h0000, 16'hFFFF);
    // widest per-dim differences, then exact hits and equal distances:
    // later equals stay behind, a farther word is turned away once full
    offer_point(point_of(20'hFFFFF, 32767, -32768, -32768, 32767, 1'b1, 1'b0));
    offer_point(point_of(1, -32768, 32767, 0, -1, 1'b0, 1'b0));
    offer_point(point_of(2, -32768, 32767, 0, -1, 1'b0, 1'b0));
    offer_point(point_of(3, -32767, 32767, 0, -1, 1'b0, 1'b0));
    offer_point(point_of(4, -32768, 32767, 0, -1, 1'b0, 1'b0));
    offer_point(point_of(5, 0, 0, 0, 0, 1'b0, 1'b1));
    // first and last on one word: one filled slot, the rest empty
    offer_point(point_of(6, 1, 2, 3, 4, 1'b1, 1'b1));

    // fill a long list, then shrink k before the search closes
    wait_for_results(1'b1);
    apply_config(16'd16, 16'd1, 16'd100, random_query(), random_query(), random_query());
    offer_point(point_of(7, 100, $urandom, $urandom, $urandom, 1'b1, 1'b0));
    offer_point(point_of(8, 90, $urandom, $urandom, $urandom, 1'b0, 1'b0));
    offer_point(point_of(9, 130, $urandom, $urandom, $urandom, 1'b0, 1'b0));
    offer_point(point_of(10, 100, $urandom, $urandom, $urandom, 1'b0, 1'b0));
    offer_point(point_of(11, 99, $urandom, $urandom, $urandom, 1'b0, 1'b0));
    wait_for_results(1'b1);
    apply_config(16'd2, 16'd1, 16'd100, query_now[1], query_now[2], query_now[3]);
    offer_point(point_of(12, 95, $urandom, $urandom, $urandom, 1'b0, 1'b0));
    offer_point(point_of(13, 100, $urandom, $urandom, $urandom, 1'b0, 1'b1));

    // zero k and zero dims count as one
    wait_for_results(1'b1);
    apply_config(16'hFFE0, 16'hFFF8, random_query(), random_query(), random_query(),
                 random_query());
    offer_point(point_of(14, $urandom, $urandom, $urandom, $urandom, 1'b1, 1'b1));
    offer_point(point_of(15, $urandom, $urandom, $urandom, $urandom, 1'b1, 1'b0));
    offer_point(point_of(16, $urandom, $urandom, $urandom, $urandom, 1'b0, 1'b1));

    // k and dims above range are clipped; largest possible distance
    wait_for_results(1'b1);
    apply_config(16'd31, 16'd7, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    offer_point(point_of(17, -32768, -32768, -32768, -32768, 1'b1, 1'b0));
    offer_point(point_of(18, 32767, 32767, 32767, 32767, 1'b0, 1'b0));
    offer_point(point_of(19, -32768, -32768, -32768, -32768, 1'b0, 1'b1));

    // --- random part, in config phases ---
    random_left = RANDOM_POINTS;
    phase = 0;
    while (random_left > 0) begin
      wait_for_results(1'b1);
      calm <= (phase == 2);
      if (phase == 0) begin
        k_pick    = MAX_NEIGHBOURS_DEF;
        dims_pick = MAX_DIMS;
      end else if (phase == 1) begin
        k_pick    = 1;
        dims_pick = 2;
      end else begin
        k_pick    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
        dims_pick = $urandom_range(0, 7);
      end
      apply_config((CFG_DATA_W'($urandom) & 16'hFFE0) | CFG_DATA_W'(k_pick),
                   (CFG_DATA_W'($urandom) & 16'hFFF8) | CFG_DATA_W'(dims_pick),
                   random_query(), random_query(), random_query(), random_query());
      phase_left = PHASE_POINTS;
      while (phase_left > 0 && random_left > 0) begin
        len = $urandom_range(1, k_now + 6);
        if (len > random_left) len = random_left;
        run_sequence(len, $urandom_range(0, 9) == 0);
        phase_left  -= len;
        random_left -= len;
        // now and then the sender holds back until the list is out
        if ($urandom_range(0, 5) == 0) wait_for_results(1'b0);
      end
      phase++;
    end

    // drain, then a few quiet cycles for anything stray
    wait_for_results(1'b1);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
